[rtl/core/hcbc_pkg.sv]
// shared types and constants for the hashed coverage bitmap counter
// used by hcbc_ctrl, hcbc_dp and hashed_coverage_bitmap_counter; no dependencies
`default_nettype none

package hcbc_pkg;

    localparam int MAP_INDEX_BITS = 16;
    localparam int MAP_DEPTH      = 1 << MAP_INDEX_BITS;

    localparam logic [31:0] HASH_GOLDEN = 32'h9E37_79B1;
    localparam logic [31:0] SALT_STORE  = 32'hAAAA_AAAA;
    localparam logic [31:0] SALT_LOAD   = 32'h5555_5555;
    localparam logic [31:0] HASH_TOGGLE = 32'hDEAD_BEEF;
    localparam logic [31:0] HASH_FSM    = 32'hCAFE_BABE;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;

    // event codes
    localparam logic [1:0] OP_INSTR  = 2'd0;
    localparam logic [1:0] OP_MEM    = 2'd1;
    localparam logic [1:0] OP_REG    = 2'd2;
    localparam logic [1:0] OP_STRUCT = 2'd3;

    // which hash a bump uses
    localparam logic [1:0] SEL_SINGLE = 2'd0;
    localparam logic [1:0] SEL_LINE   = 2'd1;
    localparam logic [1:0] SEL_TOGGLE = 2'd2;
    localparam logic [1:0] SEL_FSM    = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] program_counter;
        logic [31:0] access_address;
        logic        is_store;
        logic [7:0]  register_number;
        logic [31:0] register_value;
        logic [31:0] line_metric;
        logic [31:0] toggle_metric;
        logic [31:0] fsm_metric;
    } t_cov_req;

    typedef struct packed {
        logic [15:0] map_index;
        logic [7:0]  hit_count;
        logic        was_saturated;
        logic        last_of_run;
    } t_cov_res;

    typedef struct packed {
        logic                      load;
        logic                      hash;
        logic                      read;
        logic                      write;
        logic                      clear;
        logic                      last;
        logic [1:0]                sel;
        logic [MAP_INDEX_BITS-1:0] clr_addr;
    } t_cov_cmd;

endpackage

`default_nettype wire

[rtl/core/hashed_coverage_bitmap_counter.sv]
// top level of the hashed coverage bitmap counter
// depends on hcbc_pkg, hcbc_ctrl and hcbc_dp
`default_nettype none

// Coverage monitor with a map of 65536 saturating 8-bit hit counters. After
// reset the block runs a clearing pass (one map entry per cycle) with busy
// high; configuration writes are taken during it. An event is taken when
// start is high and busy is low. With enable clear the event is dropped and
// busy stays low. Otherwise an instruction, memory or register event makes
// one counter bump and a structural event makes three. Each bump runs a hash
// multiply, a map read and a map write; busy stays high from when the event is
// taken through the last map write of the event. Every bump shows its result
// on o_result for exactly one cycle with o_result_strobe high, in the cycle after
// its map write; the receiver cannot stall, so it must take every strobe. The
// strobe of the final bump of an event comes with busy already low.
module hashed_coverage_bitmap_counter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire hcbc_pkg::t_cov_req i_request,
    // result channel
    output logic                    o_result_strobe,
    output hcbc_pkg::t_cov_res      o_result,
    // enable register write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);

    hcbc_pkg::t_cov_cmd cmd;

    // sequencing: clearing pass, then hash, read, write per bump
    hcbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_request.operation),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    // hashing, the map memory and the result register
    hcbc_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_request),
        .i_cmd     (cmd),
        .o_res     (o_result),
        .o_res_vld (o_result_strobe)
    );

    // a bumped counter is never zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_result.hit_count != 8'd0))
        else $error("result shows a zero hit count");

    // saturation only ever reports the top count
    a_sat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.was_saturated) |-> (o_result.hit_count == 8'hFF))
        else $error("saturated result without full count");

    // each bump passes through hash, read and write states, so strobes never come back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobes in consecutive cycles");

    // the final result of an event shows up once the block is free again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last_of_run) |-> !busy)
        else $error("busy still high at final result");

endmodule

`default_nettype wire

[rtl/core/hcbc_ctrl.sv]
// controller: clearing pass, request sequencing and the enable register
// depends on hcbc_pkg
`default_nettype none

module hcbc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [1:0]           i_op,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_data,
    output logic                      o_cfg_ready,
    output logic                      o_busy,
    output hcbc_pkg::t_cov_cmd        o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0]                          r_state, n_state;
    logic [1:0]                          r_sel, n_sel;
    logic [hcbc_pkg::MAP_INDEX_BITS-1:0] r_clr_addr, n_clr_addr;
    logic                                r_enable;
    logic                                last_bump;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != ST_IDLE);
    assign last_bump   = (r_sel == hcbc_pkg::SEL_SINGLE) || (r_sel == hcbc_pkg::SEL_FSM);

    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_clr_addr    = r_clr_addr;
        o_cmd         = '0;
        o_cmd.sel     = r_sel;
        o_cmd.last    = last_bump;
        o_cmd.clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start && r_enable) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_HASH;
                    n_sel      = (i_op == hcbc_pkg::OP_STRUCT) ? hcbc_pkg::SEL_LINE
                                                               : hcbc_pkg::SEL_SINGLE;
                end
            end
            ST_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                if (last_bump) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = ST_HASH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_sel      <= hcbc_pkg::SEL_SINGLE;
            r_clr_addr <= '0;
            r_enable   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_valid && o_cfg_ready) begin
                r_enable <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/hcbc_dp.sv]
// datapath: request register, hash multiplier, hit map memory, result register
// depends on hcbc_pkg
`default_nettype none

module hcbc_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire hcbc_pkg::t_cov_req   i_req,
    input  wire hcbc_pkg::t_cov_cmd   i_cmd,
    output hcbc_pkg::t_cov_res        o_res,
    output logic                      o_res_vld
);

    hcbc_pkg::t_cov_req                  r_req;
    logic [31:0]                         r_prev_pc;
    logic [31:0]                         r_prod;
    logic [hcbc_pkg::MAP_INDEX_BITS-1:0] r_idx;
    logic [7:0]                          r_rd_data;
    hcbc_pkg::t_cov_res                  r_res;
    logic                                r_res_vld;
    logic [7:0]                          r_map [hcbc_pkg::MAP_DEPTH];

    logic [31:0]                         single_key;
    logic [31:0]                         operand;
    logic [31:0]                         factor;
    logic [hcbc_pkg::MAP_INDEX_BITS-1:0] rd_idx;
    logic [hcbc_pkg::MAP_INDEX_BITS-1:0] wr_idx;
    logic [7:0]                          wr_data;
    logic                                wr_en;
    logic                                sat;
    logic [7:0]                          new_count;

    // key of the one-bump events
    always_comb begin
        case (r_req.operation)
            hcbc_pkg::OP_INSTR: single_key = (r_prev_pc >> 1) ^ r_req.program_counter;
            hcbc_pkg::OP_MEM:   single_key = r_req.access_address ^
                                    (r_req.is_store ? hcbc_pkg::SALT_STORE
                                                    : hcbc_pkg::SALT_LOAD);
            hcbc_pkg::OP_REG:   single_key = {r_req.register_number, 24'd0} ^
                                    r_req.register_value;
            default:            single_key = r_req.access_address;
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            hcbc_pkg::SEL_SINGLE: begin
                operand = single_key;
                factor  = hcbc_pkg::HASH_GOLDEN;
            end
            hcbc_pkg::SEL_LINE: begin
                operand = r_req.line_metric;
                factor  = hcbc_pkg::HASH_GOLDEN;
            end
            hcbc_pkg::SEL_TOGGLE: begin
                operand = r_req.toggle_metric;
                factor  = hcbc_pkg::HASH_TOGGLE;
            end
            default: begin
                operand = r_req.fsm_metric;
                factor  = hcbc_pkg::HASH_FSM;
            end
        endcase
    end

    // one-bump events take the upper half of the product, structural the lower
    assign rd_idx = (i_cmd.sel == hcbc_pkg::SEL_SINGLE) ?
                    r_prod[16 +: hcbc_pkg::MAP_INDEX_BITS] :
                    r_prod[hcbc_pkg::MAP_INDEX_BITS-1:0];

    assign sat       = (r_rd_data == hcbc_pkg::COUNT_MAX);
    assign new_count = sat ? hcbc_pkg::COUNT_MAX : r_rd_data + 8'd1;

    assign wr_en   = i_cmd.clear || i_cmd.write;
    assign wr_idx  = i_cmd.clear ? i_cmd.clr_addr : r_idx;
    assign wr_data = i_cmd.clear ? 8'd0 : new_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_idx] <= wr_data;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_map[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.hash) begin
            r_prod <= operand * factor;
        end
        if (i_cmd.read) begin
            r_idx <= rd_idx;
        end
        if (i_cmd.write) begin
            r_res.map_index     <= 16'(r_idx);
            r_res.hit_count     <= new_count;
            r_res.was_saturated <= sat;
            r_res.last_of_run   <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pc <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.write;
            if (i_cmd.hash && i_cmd.sel == hcbc_pkg::SEL_SINGLE &&
                r_req.operation == hcbc_pkg::OP_INSTR) begin
                r_prev_pc <= r_req.program_counter;
            end
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// testbench for hashed_coverage_bitmap_counter: directed and random coverage events,
// each result checked against a behavioral hit map kept here; needs hcbc_pkg and the rtl
module tb;

    // the clearing pass after reset alone visits every one of the MAP_DEPTH map entries
    localparam int CYCLE_LIMIT   = 300000;
    // final bump strobes in the cycle busy drops, so a short settle is plenty
    localparam int SETTLE_CYCLES = 16;

    localparam logic [1:0] ALL_OPS [4] = '{hcbc_pkg::OP_INSTR, hcbc_pkg::OP_MEM,
                                           hcbc_pkg::OP_REG, hcbc_pkg::OP_STRUCT};

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    hcbc_pkg::t_cov_req i_request   = '0;
    logic               o_result_strobe;
    hcbc_pkg::t_cov_res o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data  = 1'b0;

    // own copy of the block state
    logic [7:0]  model_hits [hcbc_pkg::MAP_DEPTH];
    logic [31:0] model_prev_pc = '0;
    logic        model_enable  = 1'b0;

    // bumps predicted but not yet seen on the result port, oldest first
    hcbc_pkg::t_cov_res pending_hits [$];

    int     error_count = 0;
    int     idle_pct    = 0;
    longint cycle_count = 0;

    hashed_coverage_bitmap_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // hit map prediction
    // ------------------------------------------------------------------

    // one saturating bump of the counter picked by the low index bits
    function automatic void bump_hit(input logic [31:0] index_word, input logic last);
        logic [hcbc_pkg::MAP_INDEX_BITS-1:0] idx;
        hcbc_pkg::t_cov_res                  res;
        idx = index_word[hcbc_pkg::MAP_INDEX_BITS-1:0];
        res = '0;
        res.map_index = 16'(idx);
        if (model_hits[idx] == hcbc_pkg::COUNT_MAX) begin
            res.was_saturated = 1'b1;
        end else begin
            model_hits[idx] = model_hits[idx] + 8'd1;
        end
        res.hit_count   = model_hits[idx];
        res.last_of_run = last;
        pending_hits.push_back(res);
    endfunction

    // all products wrap at 32 bits; single bumps take the upper half of the product
    function automatic void predict_hits(input hcbc_pkg::t_cov_req r);
        logic [31:0] h;
        logic [31:0] salt;
        if (!model_enable) begin
            return;
        end
        case (r.operation)
            hcbc_pkg::OP_INSTR: begin
                // edge from previous pc to this one, then this pc becomes the previous
                h = ((model_prev_pc >> 1) ^ r.program_counter) * hcbc_pkg::HASH_GOLDEN;
                bump_hit(h >> 16, 1'b1);
                model_prev_pc = r.program_counter;
            end
            hcbc_pkg::OP_MEM: begin
                salt = r.is_store ? hcbc_pkg::SALT_STORE : hcbc_pkg::SALT_LOAD;
                h = (r.access_address ^ salt) * hcbc_pkg::HASH_GOLDEN;
                bump_hit(h >> 16, 1'b1);
            end
            hcbc_pkg::OP_REG: begin
                h = ({r.register_number, 24'd0} ^ r.register_value) * hcbc_pkg::HASH_GOLDEN;
                bump_hit(h >> 16, 1'b1);
            end
            default: begin
                // structural: line, toggle, fsm in order, low half of each product
                h = r.line_metric * hcbc_pkg::HASH_GOLDEN;
                bump_hit(h, 1'b0);
                h = r.toggle_metric * hcbc_pkg::HASH_TOGGLE;
                bump_hit(h, 1'b0);
                h = r.fsm_metric * hcbc_pkg::HASH_FSM;
                bump_hit(h, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking and request tracking, all on the rising edge
    // results are compared before the request taken at the same edge is predicted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        hcbc_pkg::t_cov_res want;
        if (i_rst_n) begin
            if (o_result_strobe === 1'b1) begin
                if (pending_hits.size() == 0) begin
                    $error("unexpected result: map_index %0d hit_count %0d",
                           o_result.map_index, o_result.hit_count);
                    error_count++;
                end else begin
                    want = pending_hits.pop_front();
                    check_field("map_index", 32'(want.map_index),
                                32'(o_result.map_index));
                    check_field("hit_count", 32'(want.hit_count),
                                32'(o_result.hit_count));
                    check_field("was_saturated", 32'(want.was_saturated),
                                32'(o_result.was_saturated));
                    check_field("last_of_run", 32'(want.last_of_run),
                                32'(o_result.last_of_run));
                end
            end
            // request taken at this edge
            if (start && busy === 1'b0) begin
                predict_hits(i_request);
            end
            // enable register write; never overlaps a request
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                model_enable = i_cfg_data;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL hashed_coverage_bitmap_counter");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers: everything changes on the falling edge
    // ------------------------------------------------------------------

    // start stays high after acceptance so back-to-back requests need no gap;
    // the next call either replaces the request or drops start for a while
    task automatic send_event(input hcbc_pkg::t_cov_req r);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_request <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // drop start and wait until every predicted bump has come back
    task automatic drain_hits();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        // disabled events leave nothing to wait on, so let the block settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with no request pending
    task automatic write_enable(input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random contents everywhere, fields unused by the op included
    function automatic hcbc_pkg::t_cov_req random_fields(input logic [1:0] op);
        logic [223:0]       raw;
        hcbc_pkg::t_cov_req r;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(hcbc_pkg::t_cov_req)-1:0];
        r.operation = op;
        return r;
    endfunction

    // half the events come from small pools so counters climb and edges repeat
    function automatic hcbc_pkg::t_cov_req random_event();
        hcbc_pkg::t_cov_req r;
        r = random_fields(ALL_OPS[$urandom_range(0, 3)]);
        if ($urandom_range(0, 1)) begin
            r.program_counter = 32'h0000_1000 + ($urandom_range(0, 7) << 2);
            r.access_address  = 32'h8000_0000 + ($urandom_range(0, 7) << 2);
            r.register_number = 8'($urandom_range(0, 3));
            r.register_value  = 32'($urandom_range(0, 3));
            r.line_metric     = 32'($urandom_range(0, 7));
            r.toggle_metric   = 32'($urandom_range(0, 7));
            r.fsm_metric      = 32'($urandom_range(0, 7));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // enable is clear out of reset: requests are dropped, write lands during clearing
    task automatic test_disabled_after_reset();
        write_enable(1'b0);
        send_event(random_fields(hcbc_pkg::OP_INSTR));
        send_event(random_fields(hcbc_pkg::OP_MEM));
        send_event(random_fields(hcbc_pkg::OP_REG));
        send_event(random_fields(hcbc_pkg::OP_STRUCT));
        drain_hits();
        write_enable(1'b1);
    endtask

    // extremes of every field for every op
    task automatic test_field_extremes();
        hcbc_pkg::t_cov_req r;
        r = random_fields(hcbc_pkg::OP_INSTR);
        r.program_counter = 32'h0000_0000;
        send_event(r);
        r = random_fields(hcbc_pkg::OP_INSTR);
        r.program_counter = 32'hFFFF_FFFF;
        send_event(r);
        r = random_fields(hcbc_pkg::OP_INSTR);
        r.program_counter = 32'h0000_0000;
        send_event(r);
        for (int k = 0; k < 4; k++) begin
            r = random_fields(hcbc_pkg::OP_MEM);
            r.access_address = k[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            r.is_store       = k[1];
            send_event(r);
        end
        for (int k = 0; k < 4; k++) begin
            r = random_fields(hcbc_pkg::OP_REG);
            r.register_number = k[0] ? 8'hFF : 8'h00;
            r.register_value  = k[1] ? 32'hFFFF_FFFF : 32'h0000_0000;
            send_event(r);
        end
        // all metrics zero: one counter bumped three times in one event
        r = random_fields(hcbc_pkg::OP_STRUCT);
        r.line_metric   = '0;
        r.toggle_metric = '0;
        r.fsm_metric    = '0;
        send_event(r);
        r = random_fields(hcbc_pkg::OP_STRUCT);
        r.line_metric   = '1;
        r.toggle_metric = '1;
        r.fsm_metric    = '1;
        send_event(r);
        // line and fsm meet on index zero, toggle elsewhere
        r = random_fields(hcbc_pkg::OP_STRUCT);
        r.line_metric   = '0;
        r.toggle_metric = '1;
        r.fsm_metric    = '0;
        send_event(r);
        drain_hits();
    endtask

    // disabled events leave map and previous pc alone; re-enable keeps both
    task automatic test_enable_toggle();
        write_enable(1'b0);
        for (int k = 0; k < 6; k++) begin
            send_event(random_fields(ALL_OPS[k % 4]));
        end
        drain_hits();
        write_enable(1'b1);
        send_event(random_fields(hcbc_pkg::OP_INSTR));
        drain_hits();
    endtask

    task automatic test_random_traffic(input int count, input int pct);
        idle_pct = pct;
        for (int k = 0; k < count; k++) begin
            // now and then hold off until everything is back
            if ($urandom_range(0, 24) == 0) begin
                drain_hits();
            end
            send_event(random_event());
        end
        drain_hits();
    endtask

    // hammer index zero until it saturates
    task automatic test_saturation();
        hcbc_pkg::t_cov_req r;
        idle_pct = 0;
        for (int k = 0; k < 90; k++) begin
            r = random_fields(hcbc_pkg::OP_STRUCT);
            r.line_metric   = '0;
            r.toggle_metric = '0;
            r.fsm_metric    = '0;
            send_event(r);
        end
        drain_hits();
    endtask

    initial begin
        foreach (model_hits[i]) begin
            model_hits[i] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_after_reset();
        test_field_extremes();
        test_enable_toggle();
        test_random_traffic(52, 35);
        test_random_traffic(52, 45);
        test_random_traffic(52, 0);
        test_saturation();

        drain_hits();
        if (error_count == 0) begin
            $display("PASS hashed_coverage_bitmap_counter");
        end else begin
            $display("FAIL hashed_coverage_bitmap_counter");
        end
        $finish;
    end

endmodule
